// File: src/ipt_pkg.sv
`timescale 1ns / 1ps
package ipt_pkg;

  localparam int ENTRIES     = 32;
  localparam int PRUNE_ABOVE = 20;
  localparam int IW          = $clog2(ENTRIES);
  localparam int CW          = $clog2(ENTRIES + 1);
  localparam int PW          = 7;
  localparam logic [19:0] USEC_PER_SEC = 20'd1000000;

  typedef enum logic [1:0] {
    CMD_SEND  = 2'd0,
    CMD_REPLY = 2'd1,
    CMD_CHECK = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e_t;

  typedef enum logic [2:0] {
    KIND_STORED  = 3'd0,
    KIND_REFUSED = 3'd1,
    KIND_MATCHED = 3'd2,
    KIND_UNKNOWN = 3'd3,
    KIND_EXPIRED = 3'd4,
    KIND_STATUS  = 3'd5
  } kind_e_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_MIN,
    ST_XEMIT,
    ST_STORE,
    ST_STATUS,
    ST_WAIT
  } state_t;

  typedef enum logic [1:0] {
    PH_PRE,
    PH_POST,
    PH_CHK
  } phase_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] seq;
    logic [31:0] stamp_sec;
    logic [19:0] stamp_usec;
    logic [31:0] now_sec;
  } in_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] out_seq;
    logic [31:0] time_sec;
    logic [19:0] time_usec;
    logic [31:0] rtt_sec;
    logic [19:0] rtt_usec;
    logic        any_outstanding;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [15:0] seq;
    logic [31:0] sec;
    logic [19:0] usec;
  } entry_t;

endpackage

// File: src/inflight_probe_tracker_unit.sv
`timescale 1ns / 1ps
// Table of up to ENTRIES outstanding echo probes kept in one single-port-read RAM.
// Every send, reply or check walks the whole table through the RAM read port
// and then takes a decide step, and each expired probe reported costs one more
// walk to pick the lowest sequence number plus an emit step and its output beat.
// A command stalls while one of its output beats is held off, and in_ready is
// low for the whole command.
// Results leave through a single output register; any_outstanding tells the
// table state after the whole command and last marks its final beat.
module inflight_probe_tracker_unit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  ipt_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output ipt_pkg::out_t out_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [31:0]   cfg_data
);
  import ipt_pkg::*;

  state_t state_r, state_nxt, ret_r, ret_nxt;
  phase_t ph_r, ph_nxt;
  in_t    item_r, item_nxt;
  out_t   out_r, out_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic [31:0] timeout_r, limit_r, limit_nxt;
  logic   age_en_r, age_en_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt, rem_r, rem_nxt, count_r, count_nxt, fc_r, fc_nxt;
  logic [ENTRIES-1:0] valid_r, valid_nxt, exp_r, exp_nxt;
  logic   hit_r, hit_nxt, free_v_r, free_v_nxt;
  logic [IW-1:0] hit_idx_r, hit_idx_nxt, free_idx_r, free_idx_nxt, fe_idx_r, fe_idx_nxt;
  logic [31:0] hsec_r, hsec_nxt;
  logic [19:0] husec_r, husec_nxt;
  logic   best_v_r, best_v_nxt;
  logic [IW-1:0] best_idx_r, best_idx_nxt;
  entry_t best_r, best_nxt;

  entry_t rd;
  entry_t wr;
  logic   we;
  logic [IW-1:0] slot, kk;
  logic   newexp, prune, is_new;
  logic [CW-1:0] c1, n2;
  logic [20:0] usum;
  logic   borrow;

  ipt_ram #(.WIDTH($bits(entry_t)), .DEPTH(ENTRIES)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (slot),
    .wdata (wr),
    .raddr (cnt_r[IW-1:0]),
    .rdata (rd)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign kk     = IW'(cnt_r - CW'(1));
  assign slot   = hit_r ? hit_idx_r : (free_v_r ? free_idx_r : fe_idx_r);
  assign newexp = age_en_r && (item_r.stamp_sec < limit_r);
  assign is_new = !hit_r;
  assign c1     = count_r + CW'(is_new);
  assign n2     = rem_r - CW'(exp_r[slot]) + CW'(newexp);
  assign prune  = PW'(c1) > PW'(PRUNE_ABOVE);
  assign we     = (state_r == ST_STORE);
  assign wr     = '{seq: item_r.seq, sec: item_r.stamp_sec, usec: item_r.stamp_usec};
  assign borrow = item_r.stamp_usec < husec_r;
  assign usum   = {1'b0, item_r.stamp_usec} + (borrow ? {1'b0, USEC_PER_SEC} : 21'd0)
                  - {1'b0, husec_r};

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && cmd_e_t'(in_data.cmd) != CMD_NONE) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (cnt_r == CW'(ENTRIES)) state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        case (cmd_e_t'(item_r.cmd))
          CMD_SEND: begin
            if (hit_r || free_v_r) state_nxt = ST_STORE;
            else if (rem_r != '0) state_nxt = ST_MIN;
            else state_nxt = ST_WAIT;
          end
          CMD_REPLY: state_nxt = ST_WAIT;
          CMD_CHECK: state_nxt = (rem_r != '0) ? ST_MIN : ST_STATUS;
          default:   state_nxt = ST_IDLE;
        endcase
      end
      ST_MIN: begin
        if (cnt_r == CW'(ENTRIES)) state_nxt = ST_XEMIT;
      end
      ST_XEMIT:  state_nxt = ST_WAIT;
      ST_STORE:  state_nxt = ST_WAIT;
      ST_STATUS: state_nxt = ST_WAIT;
      ST_WAIT: begin
        if (out_ready) state_nxt = ret_r;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    ret_nxt       = ret_r;
    ph_nxt        = ph_r;
    item_nxt      = item_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    limit_nxt     = limit_r;
    age_en_nxt    = age_en_r;
    cnt_nxt       = cnt_r;
    rem_nxt       = rem_r;
    count_nxt     = count_r;
    fc_nxt        = fc_r;
    valid_nxt     = valid_r;
    exp_nxt       = exp_r;
    hit_nxt       = hit_r;
    hit_idx_nxt   = hit_idx_r;
    free_v_nxt    = free_v_r;
    free_idx_nxt  = free_idx_r;
    fe_idx_nxt    = fe_idx_r;
    hsec_nxt      = hsec_r;
    husec_nxt     = husec_r;
    best_v_nxt    = best_v_r;
    best_idx_nxt  = best_idx_r;
    best_nxt      = best_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          item_nxt   = in_data;
          limit_nxt  = in_data.now_sec - timeout_r;
          age_en_nxt = in_data.now_sec >= timeout_r;
          cnt_nxt    = '0;
          hit_nxt    = 1'b0;
          free_v_nxt = 1'b0;
        end
      end
      ST_SCAN: begin
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r != '0) begin
          if (valid_r[kk] && rd.seq == item_r.seq) begin
            hit_nxt     = 1'b1;
            hit_idx_nxt = kk;
            hsec_nxt    = rd.sec;
            husec_nxt   = rd.usec;
          end
          if (valid_r[kk] && age_en_r && rd.sec < limit_r) begin
            exp_nxt[kk] = 1'b1;
            rem_nxt     = rem_r + CW'(1);
            if (rem_r == '0) fe_idx_nxt = kk;
          end
          if (!valid_r[kk] && !free_v_r) begin
            free_v_nxt   = 1'b1;
            free_idx_nxt = kk;
          end
        end
      end
      ST_DECIDE: begin
        out_nxt    = '0;
        cnt_nxt    = '0;
        best_v_nxt = 1'b0;
        case (cmd_e_t'(item_r.cmd))
          CMD_SEND: begin
            if (!hit_r && !free_v_r) begin
              if (rem_r != '0) begin
                // full table: age first, then store into the lowest freed slot
                ph_nxt = PH_PRE;
                if (PW'(count_r - rem_r + CW'(1)) > PW'(PRUNE_ABOVE))
                  fc_nxt = count_r - rem_r + CW'(1) - CW'(newexp);
                else
                  fc_nxt = count_r - rem_r + CW'(1);
              end else begin
                out_valid_nxt           = 1'b1;
                out_nxt.kind            = KIND_REFUSED;
                out_nxt.out_seq         = item_r.seq;
                out_nxt.any_outstanding = count_r != '0;
                out_nxt.last            = 1'b1;
                ret_nxt                 = ST_IDLE;
              end
            end
          end
          CMD_REPLY: begin
            exp_nxt       = '0;
            rem_nxt       = '0;
            out_valid_nxt = 1'b1;
            out_nxt.out_seq = item_r.seq;
            out_nxt.last    = 1'b1;
            ret_nxt         = ST_IDLE;
            if (hit_r) begin
              out_nxt.kind            = KIND_MATCHED;
              out_nxt.time_sec        = item_r.stamp_sec;
              out_nxt.time_usec       = item_r.stamp_usec;
              out_nxt.rtt_sec         = item_r.stamp_sec - hsec_r - 32'(borrow);
              out_nxt.rtt_usec        = usum[19:0];
              out_nxt.any_outstanding = (count_r - CW'(1)) != '0;
              valid_nxt[hit_idx_r]    = 1'b0;
              count_nxt               = count_r - CW'(1);
            end else begin
              out_nxt.kind            = KIND_UNKNOWN;
              out_nxt.any_outstanding = count_r != '0;
            end
          end
          CMD_CHECK: begin
            ph_nxt = PH_CHK;
            fc_nxt = count_r - rem_r;
          end
          default: ;
        endcase
      end
      ST_MIN: begin
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r != '0 && exp_r[kk] && (!best_v_r || rd.seq < best_r.seq)) begin
          best_v_nxt   = 1'b1;
          best_idx_nxt = kk;
          best_nxt     = rd;
        end
      end
      ST_XEMIT: begin
        out_valid_nxt           = 1'b1;
        out_nxt                 = '0;
        out_nxt.kind            = KIND_EXPIRED;
        out_nxt.out_seq         = best_r.seq;
        out_nxt.time_sec        = best_r.sec;
        out_nxt.time_usec       = best_r.usec;
        out_nxt.any_outstanding = fc_r != '0;
        out_nxt.last            = (ph_r == PH_POST) && (rem_r == CW'(1));
        valid_nxt[best_idx_r]   = 1'b0;
        exp_nxt[best_idx_r]     = 1'b0;
        count_nxt               = count_r - CW'(1);
        rem_nxt                 = rem_r - CW'(1);
        cnt_nxt                 = '0;
        best_v_nxt              = 1'b0;
        if (rem_r != CW'(1)) ret_nxt = ST_MIN;
        else if (ph_r == PH_PRE) ret_nxt = ST_STORE;
        else if (ph_r == PH_CHK) ret_nxt = ST_STATUS;
        else ret_nxt = ST_IDLE;
      end
      ST_STORE: begin
        valid_nxt[slot] = 1'b1;
        count_nxt       = c1;
        ph_nxt          = PH_POST;
        cnt_nxt         = '0;
        best_v_nxt      = 1'b0;
        if (prune) begin
          exp_nxt[slot] = newexp;
          rem_nxt       = n2;
          fc_nxt        = c1 - n2;
        end else begin
          exp_nxt = '0;
          rem_nxt = '0;
          fc_nxt  = c1;
        end
        out_valid_nxt           = 1'b1;
        out_nxt                 = '0;
        out_nxt.kind            = KIND_STORED;
        out_nxt.out_seq         = item_r.seq;
        out_nxt.any_outstanding = prune ? (c1 - n2) != '0 : c1 != '0;
        out_nxt.last            = !(prune && n2 != '0);
        ret_nxt                 = (prune && n2 != '0) ? ST_MIN : ST_IDLE;
      end
      ST_STATUS: begin
        out_valid_nxt           = 1'b1;
        out_nxt                 = '0;
        out_nxt.kind            = KIND_STATUS;
        out_nxt.any_outstanding = fc_r != '0;
        out_nxt.last            = 1'b1;
        ret_nxt                 = ST_IDLE;
      end
      ST_WAIT: begin
        if (out_ready) out_valid_nxt = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ret_r       <= ST_IDLE;
      ph_r        <= PH_CHK;
      out_valid_r <= 1'b0;
      timeout_r   <= 32'd5;
      cnt_r       <= '0;
      rem_r       <= '0;
      count_r     <= '0;
      fc_r        <= '0;
      valid_r     <= '0;
      exp_r       <= '0;
      hit_r       <= 1'b0;
      free_v_r    <= 1'b0;
      best_v_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      ph_r        <= ph_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) timeout_r <= cfg_data;
      cnt_r       <= cnt_nxt;
      rem_r       <= rem_nxt;
      count_r     <= count_nxt;
      fc_r        <= fc_nxt;
      valid_r     <= valid_nxt;
      exp_r       <= exp_nxt;
      hit_r       <= hit_nxt;
      free_v_r    <= free_v_nxt;
      best_v_r    <= best_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r       <= item_nxt;
    out_r        <= out_nxt;
    limit_r      <= limit_nxt;
    age_en_r     <= age_en_nxt;
    hit_idx_r    <= hit_idx_nxt;
    free_idx_r   <= free_idx_nxt;
    fe_idx_r     <= fe_idx_nxt;
    hsec_r       <= hsec_nxt;
    husec_r      <= husec_nxt;
    best_idx_r   <= best_idx_nxt;
    best_r       <= best_nxt;
  end

  // expiry marks are all consumed by the end of every command
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (exp_r == '0 && rem_r == '0))
    else $error("expiry marks left over at idle");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(ENTRIES))
    else $error("entry count above table size");

  a_ready_no_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid_r)
    else $error("new command taken with a result beat pending");

  a_rem_le_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MIN || state_r == ST_XEMIT) |-> (rem_r != '0 && rem_r <= count_r))
    else $error("expiry walk without pending expired entries");

endmodule

// File: src/ipt_ram.sv
`timescale 1ns / 1ps
module ipt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
